[design/adccs_pkg.sv]
`default_nettype none

package adccs_pkg;

    // Number of quotient bits produced by the shared divider, one per cycle.
    localparam int unsigned DIV_STEPS = 16;

    // Input word kinds.
    localparam logic KIND_TRIGGER = 1'b0;
    localparam logic KIND_RESULT  = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SCAN_ENABLED = 3'd0;
    localparam logic [2:0] CFG_VREF_SOURCE  = 3'd1;
    localparam logic [2:0] CFG_CHAN0_SOURCE = 3'd2;
    localparam logic [2:0] CFG_CHAN1_SOURCE = 3'd3;
    localparam logic [2:0] CFG_CHAN2_SOURCE = 3'd4;
    localparam logic [2:0] CFG_CHAN3_SOURCE = 3'd5;
    localparam logic [2:0] CFG_REFERENCE_MV = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [15:0] REFERENCE_MV_RESET = 16'd1200;
    localparam logic [7:0]  CHAN0_RESET        = 8'd1;
    localparam logic [7:0]  CHAN1_RESET        = 8'd2;
    localparam logic [7:0]  CHAN2_RESET        = 8'd3;
    localparam logic [7:0]  CHAN3_RESET        = 8'd4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  result_source;
        logic [15:0] result_reading;
    } in_item_t;

    typedef struct packed {
        logic        handled;
        logic        request_valid;
        logic [7:0]  request_source;
        logic        stored_valid;
        logic [1:0]  stored_channel;
        logic [15:0] stored_mv;
        logic        scan_done;
        logic        scan_busy;
        logic        last;
    } out_item_t;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    // Response from the shared divider; the quotient is saturated to 16 bits.
    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_OUT0,
        ST_OUT1
    } seq_state_t;

endpackage

`default_nettype wire

[design/adccs_div.sv]
`default_nettype none

module adccs_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire adccs_pkg::div_req_t req,
    output adccs_pkg::div_rsp_t      rsp
);
    import adccs_pkg::*;

    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;

    logic [16:0] rem_sh;
    logic [16:0] diff;
    logic        ge;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign rem_sh = {rem_reg, quo_reg[15]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            dvs_next = req.divisor;
            // A quotient of 17 bits or more saturates at once.
            if (req.dividend[31:16] >= req.divisor) begin
                quo_next  = 16'hFFFF;
                cnt_next  = 5'd0;
                done_next = 1'b1;
            end else begin
                rem_next = req.dividend[31:16];
                quo_next = req.dividend[15:0];
                cnt_next = 5'(DIV_STEPS);
            end
        end else if (cnt_reg != 5'd0) begin
            rem_next = ge ? diff[15:0] : rem_sh[15:0];
            quo_next = {quo_reg[14:0], ge};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

[design/adc_channel_scan_vref_scaling_top.sv]
`default_nettype none

// ADC scan sequencer with ratiometric reference correction.
// Input channel (s_valid/s_ready/s_data) carries trigger words and ADC
// conversion results; the result channel (m_valid/m_ready/m_data) gives one
// or two words per input word, the final one marked by last. The cfg port
// writes the configuration registers and is always ready; write it only
// while no input word is in progress.
// A trigger, reference result or unmatched result is accepted and its
// first word is offered in the next cycle. A matching channel result
// passes through the multiplier state, a state that starts the divider and
// a wait on the shared radix-2 divider until it signals done, after its 16
// steps or without stepping when the quotient saturates. Without a stored
// reference count the raw reading is used and the divider is skipped, so
// the first word follows straight after the multiplier state.
// The block takes one input word at a time and s_ready is low until the
// last output word has been taken; a stalled receiver holds m_data steady.
// Reset clears the scan state, the reference count and the configuration
// registers to their defaults.
module adc_channel_scan_vref_scaling_top #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire adccs_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output adccs_pkg::out_item_t      m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_data
);
    import adccs_pkg::*;

    localparam logic [2:0] NCH = 3'(NUM_CHANNELS);

    seq_state_t  state_reg, state_next;

    logic        en_reg, en_next;
    logic [7:0]  vref_code_reg, vref_code_next;
    logic [7:0]  chan_code_reg [4];
    logic [7:0]  chan_code_next [4];
    logic [15:0] ref_mv_reg, ref_mv_next;

    logic [2:0]  scan_index_reg, scan_index_next;
    logic        busy_reg, busy_next;
    logic [15:0] vref_reg, vref_next;

    in_item_t    item_reg, item_next;
    logic [31:0] prod_reg, prod_next;
    out_item_t   res0_reg, res0_next;
    out_item_t   res1_reg, res1_next;
    logic        two_reg, two_next;

    div_req_t    div_req;
    div_rsp_t    div_rsp;

    logic        accept;
    logic        trig_start;
    logic        is_vref;
    logic        chan_hit;
    logic        finish;
    logic [15:0] mv;
    logic [2:0]  idx_inc;
    logic [1:0]  code_addr;
    logic [7:0]  code_rd;

    adccs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign idx_inc   = scan_index_reg + 3'd1;

    // One read port on the channel code table: the current slot while idle,
    // the following slot while a channel result finishes.
    assign code_addr = (state_reg == ST_IDLE) ? scan_index_reg[1:0] : idx_inc[1:0];
    assign code_rd   = chan_code_reg[code_addr];

    // Classify the incoming word.
    assign trig_start = (s_data.kind == KIND_TRIGGER) && en_reg && !busy_reg;
    assign is_vref    = (s_data.kind == KIND_RESULT) &&
                        (s_data.result_source == vref_code_reg);
    assign chan_hit   = (s_data.kind == KIND_RESULT) && !is_vref &&
                        (scan_index_reg < NCH) && (s_data.result_source == code_rd);

    // A channel result is finished when its raw or scaled value is known.
    assign finish = ((state_reg == ST_MUL) && (vref_reg == 16'd0)) ||
                    ((state_reg == ST_DIVWAIT) && div_rsp.done);
    assign mv     = (state_reg == ST_MUL) ? item_reg.result_reading : div_rsp.quotient;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = chan_hit ? ST_MUL : ST_OUT0;
                end
            end
            ST_MUL: begin
                state_next = (vref_reg == 16'd0) ? ST_OUT0 : ST_DIVGO;
            end
            ST_DIVGO: begin
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_OUT0;
                end
            end
            ST_OUT0: begin
                if (m_ready) begin
                    state_next = two_reg ? ST_OUT1 : ST_IDLE;
                end
            end
            ST_OUT1: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and divider control outputs.
    always_comb begin
        s_ready          = 1'b0;
        m_valid          = 1'b0;
        m_data           = res0_reg;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = vref_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_DIVGO: begin
                div_req.start = 1'b1;
            end
            ST_OUT0: begin
                m_valid = 1'b1;
            end
            ST_OUT1: begin
                m_valid = 1'b1;
                m_data  = res1_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Datapath and scan state.
    always_comb begin
        en_next         = en_reg;
        vref_code_next  = vref_code_reg;
        chan_code_next  = chan_code_reg;
        ref_mv_next     = ref_mv_reg;
        scan_index_next = scan_index_reg;
        busy_next       = busy_reg;
        vref_next       = vref_reg;
        item_next       = item_reg;
        prod_next       = prod_reg;
        res0_next       = res0_reg;
        res1_next       = res1_reg;
        two_next        = two_reg;

        // Configuration writes; an index beyond the list is ignored.
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SCAN_ENABLED: en_next           = cfg_data[0];
                CFG_VREF_SOURCE:  vref_code_next    = cfg_data[7:0];
                CFG_CHAN0_SOURCE: chan_code_next[0] = cfg_data[7:0];
                CFG_CHAN1_SOURCE: chan_code_next[1] = cfg_data[7:0];
                CFG_CHAN2_SOURCE: chan_code_next[2] = cfg_data[7:0];
                CFG_CHAN3_SOURCE: chan_code_next[3] = cfg_data[7:0];
                CFG_REFERENCE_MV: ref_mv_next       = cfg_data;
                default: begin
                end
            endcase
        end

        // Accepted words; all but a matching channel result are answered straight away.
        if (accept) begin
            item_next = s_data;
            res0_next = '0;
            res1_next = '0;
            two_next  = 1'b0;
            res0_next.handled   = 1'b1;
            res0_next.scan_busy = busy_reg;
            res0_next.last      = 1'b1;
            if (s_data.kind == KIND_TRIGGER) begin
                if (trig_start) begin
                    busy_next                = 1'b1;
                    scan_index_next          = 3'd0;
                    two_next                 = 1'b1;
                    res0_next.request_valid  = 1'b1;
                    res0_next.request_source = vref_code_reg;
                    res0_next.scan_busy      = 1'b1;
                    res0_next.last           = 1'b0;
                    res1_next.handled        = 1'b1;
                    res1_next.request_valid  = 1'b1;
                    res1_next.request_source = chan_code_reg[0];
                    res1_next.scan_busy      = 1'b1;
                    res1_next.last           = 1'b1;
                end
            end else if (is_vref) begin
                vref_next = s_data.result_reading;
            end else if (!chan_hit) begin
                res0_next.handled = 1'b0;
            end
        end

        // Ratiometric product, registered before the divider.
        if (state_reg == ST_MUL) begin
            prod_next = 32'(item_reg.result_reading) * 32'(ref_mv_reg);
        end

        // Store the scaled or raw value and move on to the next slot.
        if (finish) begin
            scan_index_next        = idx_inc;
            res0_next              = '0;
            res1_next              = '0;
            res0_next.handled      = 1'b1;
            res0_next.stored_valid = 1'b1;
            res0_next.stored_channel = scan_index_reg[1:0];
            res0_next.stored_mv    = mv;
            if (idx_inc >= NCH) begin
                busy_next           = 1'b0;
                two_next            = 1'b0;
                res0_next.scan_done = 1'b1;
                res0_next.scan_busy = 1'b0;
                res0_next.last      = 1'b1;
            end else begin
                two_next                 = 1'b1;
                res0_next.request_valid  = 1'b1;
                res0_next.request_source = vref_code_reg;
                res0_next.scan_busy      = busy_reg;
                res1_next.handled        = 1'b1;
                res1_next.request_valid  = 1'b1;
                res1_next.request_source = code_rd;
                res1_next.scan_busy      = busy_reg;
                res1_next.last           = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            en_reg           <= 1'b0;
            vref_code_reg    <= 8'd0;
            chan_code_reg[0] <= CHAN0_RESET;
            chan_code_reg[1] <= CHAN1_RESET;
            chan_code_reg[2] <= CHAN2_RESET;
            chan_code_reg[3] <= CHAN3_RESET;
            ref_mv_reg       <= REFERENCE_MV_RESET;
            scan_index_reg   <= 3'd0;
            busy_reg         <= 1'b0;
            vref_reg         <= 16'd0;
            two_reg          <= 1'b0;
        end else begin
            state_reg      <= state_next;
            en_reg         <= en_next;
            vref_code_reg  <= vref_code_next;
            chan_code_reg  <= chan_code_next;
            ref_mv_reg     <= ref_mv_next;
            scan_index_reg <= scan_index_next;
            busy_reg       <= busy_next;
            vref_reg       <= vref_next;
            two_reg        <= two_next;
        end
        item_reg <= item_next;
        prod_reg <= prod_next;
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

endmodule

`default_nettype wire

[tb/sv/tb_adc_channel_scan_vref_scaling_top.sv]
`default_nettype none

module tb_adc_channel_scan_vref_scaling_top;

    import adccs_pkg::*;

    localparam int SLOTS          = 4;
    localparam int TARGET_WORDS   = 1400;
    localparam int PHASE_WORDS    = 100;
    localparam int STALL_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_PRINTS     = 40;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_op_t;

    // One line of the directed table: a register write or an input word,
    // optionally with its result words written out by hand.
    typedef struct packed {
        row_op_t     op;
        logic [2:0]  reg_idx;
        logic [15:0] reg_data;
        in_item_t    word;
        logic [1:0]  n_typed;
        out_item_t   typed0;
        out_item_t   typed1;
    } dir_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    adc_channel_scan_vref_scaling_top #(
        .NUM_CHANNELS(SLOTS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic        c_enabled  = 1'b0;
    logic [7:0]  c_vref_src = 8'h00;
    logic [7:0]  c_chan_src [SLOTS] = '{CHAN0_RESET, CHAN1_RESET, CHAN2_RESET, CHAN3_RESET};
    logic [15:0] c_ref_mv   = REFERENCE_MV_RESET;

    // Shadow copy of the scan state.
    logic [2:0]  p_scan_idx = '0;
    logic        p_busy     = 1'b0;
    logic [15:0] p_vref     = '0;

    out_item_t   pending_results [$];
    dir_row_t    dir_rows [$];

    logic        s_open    = 1'b0;
    logic        cfg_open  = 1'b0;
    logic        no_idle   = 1'b0;
    int          rx_hold   = 0;
    int          n_fail    = 0;
    int          n_sent    = 0;
    int          n_handled = 0;
    int          n_checked = 0;
    int          n_scans   = 0;
    int          n_sat     = 0;
    int          n_raw     = 0;
    int          n_cfg     = 0;
    int          idle_cycles = 0;

    // Free-running clock; the single reset pulse is driven from the main initial block.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic out_item_t scan_word(input logic hd, input logic rv,
                                            input logic [7:0] rs, input logic sv,
                                            input logic [1:0] sc, input logic [15:0] mv,
                                            input logic done, input logic busy,
                                            input logic lst);
        out_item_t r;
        r.handled        = hd;
        r.request_valid  = rv;
        r.request_source = rs;
        r.stored_valid   = sv;
        r.stored_channel = sc;
        r.stored_mv      = mv;
        r.scan_done      = done;
        r.scan_busy      = busy;
        r.last           = lst;
        return r;
    endfunction

    // Works out the result words of one input word and advances the shadow
    // scan state. Returns the number of words.
    function automatic int predict_scan(input in_item_t w, output out_item_t r0,
                                        output out_item_t r1);
        logic [31:0] product;
        logic [31:0] quot;
        logic [15:0] mv;
        logic [1:0]  slot;
        r0 = '0;
        r1 = '0;
        if (w.kind == KIND_TRIGGER) begin
            if (c_enabled && !p_busy) begin
                p_busy     = 1'b1;
                p_scan_idx = '0;
                r0 = scan_word(1'b1, 1'b1, c_vref_src, 1'b0, 2'd0, 16'd0, 1'b0, 1'b1, 1'b0);
                r1 = scan_word(1'b1, 1'b1, c_chan_src[0], 1'b0, 2'd0, 16'd0, 1'b0, 1'b1, 1'b1);
                return 2;
            end
            r0 = scan_word(1'b1, 1'b0, 8'h00, 1'b0, 2'd0, 16'd0, 1'b0, p_busy, 1'b1);
            return 1;
        end
        // The reference source is tested first, even if a slot shares its code.
        if (w.result_source == c_vref_src) begin
            p_vref = w.result_reading;
            r0 = scan_word(1'b1, 1'b0, 8'h00, 1'b0, 2'd0, 16'd0, 1'b0, p_busy, 1'b1);
            return 1;
        end
        if (p_scan_idx < SLOTS && w.result_source == c_chan_src[p_scan_idx[1:0]]) begin
            slot = p_scan_idx[1:0];
            if (p_vref != 16'd0) begin
                product = {16'd0, w.result_reading} * {16'd0, c_ref_mv};
                quot    = product / {16'd0, p_vref};
                if (quot > 32'h0000_FFFF) begin
                    mv = 16'hFFFF;
                    n_sat++;
                end else begin
                    mv = quot[15:0];
                end
            end else begin
                mv = w.result_reading;
                n_raw++;
            end
            p_scan_idx = p_scan_idx + 3'd1;
            if (p_scan_idx >= SLOTS) begin
                p_busy = 1'b0;
                r0 = scan_word(1'b1, 1'b0, 8'h00, 1'b1, slot, mv, 1'b1, 1'b0, 1'b1);
                return 1;
            end
            r0 = scan_word(1'b1, 1'b1, c_vref_src, 1'b1, slot, mv, 1'b0, p_busy, 1'b0);
            r1 = scan_word(1'b1, 1'b1, c_chan_src[p_scan_idx[1:0]], 1'b0, 2'd0, 16'd0,
                           1'b0, p_busy, 1'b1);
            return 2;
        end
        r0 = scan_word(1'b0, 1'b0, 8'h00, 1'b0, 2'd0, 16'd0, 1'b0, p_busy, 1'b1);
        return 1;
    endfunction

    task automatic report_mismatch(input string msg);
        n_fail++;
        if (n_fail <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result word %0d, %s is %h, expected %h",
                                      n_checked, name, got, want));
    endtask

    // Result channel: each word taken is compared with the oldest expectation.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word %0d arrived with none expected: %h",
                                          n_checked, m_data));
            end else begin
                want = pending_results.pop_front();
                check_field("handled",        m_data.handled,        want.handled);
                check_field("request_valid",  m_data.request_valid,  want.request_valid);
                check_field("request_source", m_data.request_source, want.request_source);
                check_field("stored_valid",   m_data.stored_valid,   want.stored_valid);
                check_field("stored_channel", m_data.stored_channel, want.stored_channel);
                check_field("stored_mv",      m_data.stored_mv,      want.stored_mv);
                check_field("scan_done",      m_data.scan_done,      want.scan_done);
                check_field("scan_busy",      m_data.scan_busy,      want.scan_busy);
                check_field("last",           m_data.last,           want.last);
            end
            if (m_data.scan_done === 1'b1)
                n_scans++;
            n_checked++;
        end
    end

    // Mostly short pauses, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(8, 40);
    endfunction

    // Receiver back-pressure.
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rx_hold = idle_len();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run if no handshake of any kind happens for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                     idle_cycles, pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drops the input valid and waits until every expected word has been taken.
    task automatic settle();
        if (s_open) begin
            s_valid <= 1'b0;
            s_open = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Writes one register. Valid is left high so that a following write in
    // the same step needs no second assignment; the next input word drops it.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        logic [1:0] ch;
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        cfg_open = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        n_cfg++;
        case (idx)
            CFG_SCAN_ENABLED: c_enabled  = data[0];
            CFG_VREF_SOURCE:  c_vref_src = data[7:0];
            CFG_CHAN0_SOURCE, CFG_CHAN1_SOURCE, CFG_CHAN2_SOURCE, CFG_CHAN3_SOURCE: begin
                ch = 2'(idx - CFG_CHAN0_SOURCE);
                c_chan_src[ch] = data[7:0];
            end
            CFG_REFERENCE_MV: c_ref_mv = data;
            default: ;
        endcase
    endtask

    // Sends one input word; typed words, where given, replace the prediction.
    task automatic issue(input in_item_t w, input logic [1:0] n_typed,
                         input out_item_t t0, input out_item_t t1);
        out_item_t r0;
        out_item_t r1;
        int        n;
        int        gap;
        if (cfg_open) begin
            cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        s_data  <= w;
        s_valid <= 1'b1;
        s_open = 1'b1;
        do @(posedge aclk); while (!s_ready);
        n = predict_scan(w, r0, r1);
        if (n_typed != 0) begin
            n = n_typed;
            r0 = t0;
            r1 = t1;
        end
        pending_results.push_back(r0);
        if (n == 2)
            pending_results.push_back(r1);
        n_sent++;
        if (r0.handled)
            n_handled++;
        gap = (no_idle || $urandom_range(0, 9) < 4) ? 0 : idle_len() + 1;
        if (gap != 0) begin
            s_valid <= 1'b0;
            s_open = 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic in_item_t make_word(input logic kind, input logic [7:0] src,
                                           input logic [15:0] rd);
        in_item_t w;
        w.kind           = kind;
        w.result_source  = src;
        w.result_reading = rd;
        return w;
    endfunction

    task automatic row_word(input logic kind, input logic [7:0] src, input logic [15:0] rd,
                            input logic [1:0] n, input out_item_t t0, input out_item_t t1);
        dir_row_t row;
        row.op       = ROW_WORD;
        row.reg_idx  = '0;
        row.reg_data = '0;
        row.word     = make_word(kind, src, rd);
        row.n_typed  = n;
        row.typed0   = t0;
        row.typed1   = t1;
        dir_rows.push_back(row);
    endtask

    task automatic row_cfg(input logic [2:0] idx, input logic [15:0] data);
        dir_row_t row;
        row = '0;
        row.op       = ROW_CFG;
        row.reg_idx  = idx;
        row.reg_data = data;
        dir_rows.push_back(row);
    endtask

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_reading();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 15));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Reference counts: zero for the raw path, tiny ones to force saturation.
    function automatic logic [15:0] pick_vref();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'($urandom_range(1, 4));
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_noise();
        issue(make_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535))), 2'd0, '0, '0);
    endtask

    // A well-formed scan with random content; now and then it is broken off
    // or interleaved with stray words.
    task automatic run_scan();
        int pairs;
        pairs = 0;
        issue(make_word(KIND_TRIGGER, 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535))), 2'd0, '0, '0);
        while (p_scan_idx < SLOTS && pairs < 6) begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            if ($urandom_range(0, 24) == 0)
                return;
            if ($urandom_range(0, 5) != 0)
                issue(make_word(KIND_RESULT, c_vref_src, pick_vref()), 2'd0, '0, '0);
            issue(make_word(KIND_RESULT, c_chan_src[p_scan_idx[1:0]], pick_reading()),
                  2'd0, '0, '0);
            pairs++;
        end
    endtask

    // A fresh register setting, extremes included; codes sometimes collide
    // with the reference code on purpose.
    task automatic random_setting();
        logic [7:0]  vref_code;
        logic [15:0] ref_mv;
        vref_code = pick_code();
        case ($urandom_range(0, 5))
            0:       ref_mv = 16'h0000;
            1:       ref_mv = 16'hFFFF;
            2:       ref_mv = REFERENCE_MV_RESET;
            default: ref_mv = 16'($urandom_range(0, 65535));
        endcase
        write_reg(CFG_SCAN_ENABLED, {15'd0, 1'($urandom_range(0, 5) != 0)});
        write_reg(CFG_VREF_SOURCE, {8'd0, vref_code});
        write_reg(CFG_CHAN0_SOURCE, {8'd0, ($urandom_range(0, 15) == 0) ? vref_code
                                                                       : pick_code()});
        write_reg(CFG_CHAN1_SOURCE, {8'd0, pick_code()});
        write_reg(CFG_CHAN2_SOURCE, {8'd0, pick_code()});
        write_reg(CFG_CHAN3_SOURCE, {8'd0, ($urandom_range(0, 15) == 0) ? vref_code
                                                                       : pick_code()});
        write_reg(CFG_REFERENCE_MV, ref_mv);
    endtask

    initial begin
        out_item_t ack_idle;
        out_item_t ack_busy;
        out_item_t nak_idle;
        int        phase;
        int        phase_start;

        ack_idle = scan_word(1'b1, 1'b0, 8'h00, 1'b0, 2'd0, 16'd0, 1'b0, 1'b0, 1'b1);
        ack_busy = scan_word(1'b1, 1'b0, 8'h00, 1'b0, 2'd0, 16'd0, 1'b0, 1'b1, 1'b1);
        nak_idle = scan_word(1'b0, 1'b0, 8'h00, 1'b0, 2'd0, 16'd0, 1'b0, 1'b0, 1'b1);

        // Directed table. Straight after reset: disabled trigger, reference
        // word, stray source, and a slot 0 word accepted with no scan running.
        row_word(KIND_TRIGGER, 8'h00, 16'h0000, 2'd1, ack_idle, '0);
        row_word(KIND_RESULT,  8'h00, 16'hFFFF, 2'd1, ack_idle, '0);
        row_word(KIND_RESULT,  8'h5A, 16'h0000, 2'd1, nak_idle, '0);
        row_word(KIND_RESULT,  8'h01, 16'h1234, 2'd0, '0, '0);
        // Enabled: a scan starts, a second trigger is refused, then a full
        // scan through raw, saturating, zero and normal conversions.
        row_cfg(CFG_SCAN_ENABLED, 16'd1);
        row_word(KIND_TRIGGER, 8'hFF, 16'hFFFF, 2'd2,
                 scan_word(1'b1, 1'b1, 8'h00, 1'b0, 2'd0, 16'd0, 1'b0, 1'b1, 1'b0),
                 scan_word(1'b1, 1'b1, 8'h01, 1'b0, 2'd0, 16'd0, 1'b0, 1'b1, 1'b1));
        row_word(KIND_TRIGGER, 8'h00, 16'h0000, 2'd1, ack_busy, '0);
        row_word(KIND_RESULT,  8'h00, 16'h0000, 2'd1, ack_busy, '0);
        row_word(KIND_RESULT,  8'h01, 16'hFFFF, 2'd0, '0, '0);
        row_word(KIND_RESULT,  8'h00, 16'h0001, 2'd1, ack_busy, '0);
        row_word(KIND_RESULT,  8'h02, 16'hFFFF, 2'd0, '0, '0);
        row_word(KIND_RESULT,  8'h00, 16'hFFFF, 2'd1, ack_busy, '0);
        row_word(KIND_RESULT,  8'h03, 16'h0000, 2'd0, '0, '0);
        row_word(KIND_RESULT,  8'h04, 16'hFFFF, 2'd0, '0, '0);
        // Index past the last slot: nothing matches.
        row_word(KIND_RESULT,  8'h04, 16'hFFFF, 2'd1, nak_idle, '0);
        // Slot 0 shares the reference code, so the reference wins.
        row_cfg(CFG_VREF_SOURCE,  16'h00FF);
        row_cfg(CFG_CHAN0_SOURCE, 16'h00FF);
        row_cfg(CFG_CHAN1_SOURCE, 16'h0000);
        row_cfg(CFG_CHAN2_SOURCE, 16'h0080);
        row_cfg(CFG_CHAN3_SOURCE, 16'h007F);
        row_cfg(CFG_REFERENCE_MV, 16'hFFFF);
        row_word(KIND_TRIGGER, 8'h00, 16'h0000, 2'd0, '0, '0);
        row_word(KIND_RESULT,  8'hFF, 16'h8000, 2'd1, ack_busy, '0);
        row_cfg(CFG_CHAN0_SOURCE, 16'h0001);
        row_word(KIND_RESULT,  8'h01, 16'h8000, 2'd0, '0, '0);
        row_word(KIND_RESULT,  8'h00, 16'h0001, 2'd0, '0, '0);
        // Disabled while busy, finishing the scan, then disabled and idle.
        row_cfg(CFG_SCAN_ENABLED, 16'd0);
        row_word(KIND_TRIGGER, 8'h00, 16'h0000, 2'd1, ack_busy, '0);
        row_word(KIND_RESULT,  8'h80, 16'h7FFF, 2'd0, '0, '0);
        row_word(KIND_RESULT,  8'h7F, 16'h5000, 2'd0, '0, '0);
        row_word(KIND_TRIGGER, 8'h00, 16'h0000, 2'd1, ack_idle, '0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) begin
                settle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
            end else begin
                issue(dir_rows[i].word, dir_rows[i].n_typed,
                      dir_rows[i].typed0, dir_rows[i].typed1);
            end
        end

        // Random phases, each under its own register setting; every fourth
        // phase runs with no pauses on either side.
        phase = 0;
        while (n_sent < TARGET_WORDS) begin
            settle();
            no_idle = (phase % 4 == 3);
            random_setting();
            phase_start = n_sent;
            while (n_sent - phase_start < PHASE_WORDS) begin
                if ($urandom_range(0, 9) < 8)
                    run_scan();
                else
                    send_noise();
            end
            phase++;
        end

        settle();
        no_idle = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived",
                                      pending_results.size()));

        $display("Sent %0d words (%0d handled) over %0d random settings, %0d register writes.",
                 n_sent, n_handled, phase, n_cfg);
        $display("Checked %0d result words: %0d scans done, %0d saturated, %0d raw readings.",
                 n_checked, n_scans, n_sat, n_raw);
        if (n_fail == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
